FILE: src/assert_macros.svh
// assertion macros used by the boost pipeline top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check on the rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// a condition that must never hold
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)
`endif

FILE: src/blf_pkg.sv
// shared types, constants and helper functions for the lorentz boost pipeline
// no dependencies
`default_nettype none

package blf_pkg;

   localparam int COMP_WIDTH_DEF   = 48;
   localparam int CORDIC_STEPS_DEF = 30;
   localparam int ISQRT_STEPS      = 31;
   localparam int DIV_STEPS        = 32;

   // internal widths: angle, cordic vector, matrix entry
   localparam int ANG_W  = 35;
   localparam int CRD_W  = 34;
   localparam int MAT_W  = 48;
   localparam int HALF_W = MAT_W / 2;

   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [31:0]      ONE_Q30     = 32'sd1073741824;
   localparam logic signed [31:0]      NEG_ONE_Q30 = -32'sd1073741824;

   typedef logic signed [MAT_W-1:0] mval_type;

   // state carried through the shared cordic / square root / divider stages
   typedef struct packed {
      logic signed [ANG_W-1:0] ang;
      logic signed [CRD_W-1:0] cx;
      logic signed [CRD_W-1:0] cy;
      logic                    flip;
      logic [61:0]             sq_rem;
      logic [61:0]             sq_res;
      logic [33:0]             dv_rem;
      logic [31:0]             dv_lo;
      logic [32:0]             dv_den;
      logic [31:0]             dv_quo;
      logic signed [31:0]      beta;
      logic signed [31:0]      mu;
      logic [31:0]             gam;
   } front_type;

   // arctangent of 2^-idx in q30
   function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         0: val = 35'sd843314857;
         1: val = 35'sd497837829;
         2: val = 35'sd263043837;
         3: val = 35'sd133525159;
         4: val = 35'sd67021687;
         5: val = 35'sd33543516;
         6: val = 35'sd16775851;
         7: val = 35'sd8388437;
         8: val = 35'sd4194283;
         9: val = 35'sd2097149;
         default: val = (idx >= 0 && idx <= 30) ? (35'sd1 <<< (30 - idx)) : '0;
      endcase
      return val;
   endfunction

   // limit a q30 value to plus or minus one
   function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
      logic signed [31:0] res;
      if (v > 36'(ONE_Q30)) begin
         res = ONE_Q30;
      end else if (v < 36'(NEG_ONE_Q30)) begin
         res = NEG_ONE_Q30;
      end else begin
         res = 32'(v);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/blf_front_stage.sv
// one stage of the shared front end: a cordic rotation, a square root digit
// and a divider quotient bit side by side; depends on blf_pkg
`default_nettype none

module blf_front_stage
   import blf_pkg::*;
#(
   parameter int STEP         = 0,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      en,
   input  front_type st_in,
   output front_type st_out
);

   localparam int SQ_EXP = (STEP < ISQRT_STEPS) ? 60 - 2 * STEP : 0;
   localparam int DV_IDX = (STEP < DIV_STEPS) ? 31 - STEP : 0;
   localparam logic [61:0] SQ_BIT = 62'd1 << SQ_EXP;
   localparam logic signed [ANG_W-1:0] ATAN = atan_q30(STEP);

   front_type st_in_w;
   front_type st_ff;
   logic signed [CRD_W-1:0] dx;
   logic signed [CRD_W-1:0] dy;
   logic [61:0] sq_trial;
   logic [33:0] dv_t;

   assign dx       = st_in.cy >>> STEP;
   assign dy       = st_in.cx >>> STEP;
   assign sq_trial = st_in.sq_res + SQ_BIT;
   assign dv_t     = {st_in.dv_rem[32:0], st_in.dv_lo[DV_IDX]};

   // next state of each unit, idle ones pass through
   always_comb begin
      st_in_w = st_in;
      if (STEP < CORDIC_STEPS) begin
         if (!st_in.ang[ANG_W-1]) begin
            st_in_w.cx  = st_in.cx - dx;
            st_in_w.cy  = st_in.cy + dy;
            st_in_w.ang = st_in.ang - ATAN;
         end else begin
            st_in_w.cx  = st_in.cx + dx;
            st_in_w.cy  = st_in.cy - dy;
            st_in_w.ang = st_in.ang + ATAN;
         end
      end
      if (STEP < ISQRT_STEPS) begin
         if (st_in.sq_rem >= sq_trial) begin
            st_in_w.sq_rem = st_in.sq_rem - sq_trial;
            st_in_w.sq_res = (st_in.sq_res >> 1) + SQ_BIT;
         end else begin
            st_in_w.sq_res = st_in.sq_res >> 1;
         end
      end
      if (STEP < DIV_STEPS) begin
         if (dv_t >= {1'b0, st_in.dv_den}) begin
            st_in_w.dv_rem = dv_t - {1'b0, st_in.dv_den};
            st_in_w.dv_quo = {st_in.dv_quo[30:0], 1'b1};
         end else begin
            st_in_w.dv_rem = dv_t;
            st_in_w.dv_quo = {st_in.dv_quo[30:0], 1'b0};
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in_w;
      end
   end

   assign st_out = st_ff;

endmodule

`default_nettype wire

FILE: src/blf_matrix.sv
// builds the symmetric 4x4 boost matrix from the front end results
// five registered stages; depends on blf_pkg
`default_nettype none

module blf_matrix
   import blf_pkg::*;
(
   input  logic      clock,
   input  logic      en,
   input  front_type fin,
   output mval_type  l_mat [4][4]
);

   // stage 1 registers
   logic signed [65:0] sx_ff, sy_ff;
   logic signed [31:0] beta1_ff, mu1_ff;
   logic [31:0]        gam1_ff, quo1_ff;
   // stage 2 registers
   logic signed [63:0] pb_ff [3];
   logic [31:0]        gam2_ff, quo2_ff;
   // stage 3 registers
   logic signed [64:0] gb_ff [3];
   logic signed [63:0] bb_ff [3][3];
   logic [31:0]        gam3_ff, quo3_ff;
   // stage 4 registers
   mval_type           l0_ff [3];
   logic signed [64:0] cb_ff [3][3];
   logic [31:0]        gam4_ff;
   // stage 5
   mval_type           l_ff [4][4];

   logic signed [CRD_W-1:0] xs, ys;
   logic signed [31:0] s_w;
   logic signed [31:0] u_w [3];
   logic signed [31:0] b_w [3];

   // direction: sin(theta) times cos and sin of phi
   assign xs  = fin.flip ? -fin.cx : fin.cx;
   assign ys  = fin.flip ? -fin.cy : fin.cy;
   assign s_w = $signed({1'b0, fin.sq_res[30:0]});

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff    <= s_w * xs;
         sy_ff    <= s_w * ys;
         beta1_ff <= fin.beta;
         mu1_ff   <= fin.mu;
         gam1_ff  <= fin.gam;
         quo1_ff  <= fin.dv_quo;
      end
   end

   // unit vector and beta times it
   assign u_w[0] = clamp_q30(36'(sx_ff >>> 30));
   assign u_w[1] = clamp_q30(36'(sy_ff >>> 30));
   assign u_w[2] = mu1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pb_ff[i] <= beta1_ff * u_w[i];
         end
         gam2_ff <= gam1_ff;
         quo2_ff <= quo1_ff;
      end
   end

   // gamma times b and the outer product of b
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_w[i] = 32'(pb_ff[i] >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            gb_ff[i] <= $signed({1'b0, gam2_ff}) * b_w[i];
            for (int j = 0; j < 3; j++) begin
               bb_ff[i][j] <= b_w[i] * b_w[j];
            end
         end
         gam3_ff <= gam2_ff;
         quo3_ff <= quo2_ff;
      end
   end

   // time-space row and c times the outer product
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            l0_ff[i] <= MAT_W'(-(gb_ff[i] >>> 16));
            for (int j = 0; j < 3; j++) begin
               cb_ff[i][j] <= $signed({1'b0, quo3_ff}) * $signed(32'(bb_ff[i][j] >>> 30));
            end
         end
         gam4_ff <= gam3_ff;
      end
   end

   // final matrix entries
   always_ff @(posedge clock) begin
      if (en) begin
         l_ff[0][0] <= $signed(MAT_W'({gam4_ff, 14'b0}));
         for (int i = 0; i < 3; i++) begin
            l_ff[0][i+1] <= l0_ff[i];
            l_ff[i+1][0] <= l0_ff[i];
            for (int j = 0; j < 3; j++) begin
               l_ff[i+1][j+1] <= ((i == j) ? MAT_W'(ONE_Q30) : '0)
                                 + MAT_W'(cb_ff[i][j] >>> 16);
            end
         end
      end
   end

   assign l_mat = l_ff;

endmodule

`default_nettype wire

FILE: src/blf_lane.sv
// one output lane: dot product of a matrix row with the input vector,
// rounding and saturation over four stages; depends on blf_pkg
`default_nettype none

module blf_lane
   import blf_pkg::*;
#(
   parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  mval_type                     l_row [4],
   input  logic signed [COMP_WIDTH-1:0] v     [4],
   output logic signed [COMP_WIDTH-1:0] comp_out,
   output logic                         sat_out
);

   localparam int NV    = (COMP_WIDTH + 31) / 32;
   localparam int ACC_W = MAT_W + COMP_WIDTH + 3;
   localparam int SH_W  = ACC_W - 30;
   localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'd1 << 29);
   localparam logic [COMP_WIDTH-1:0] MAXV = {1'b0, {(COMP_WIDTH-1){1'b1}}};
   localparam logic [COMP_WIDTH-1:0] MINV = {1'b1, {(COMP_WIDTH-1){1'b0}}};

   logic signed [24:0]      lp_w  [4][2];
   logic signed [32:0]      vc_w  [4][NV];
   logic signed [57:0]      pp_ff [4][2][NV];
   logic signed [ACC_W-1:0] col_w [4];
   logic signed [ACC_W-1:0] col_ff [4];
   logic signed [ACC_W-1:0] acc_ff;
   logic [SH_W-1:0]         sh_w;
   logic                    fits;
   logic signed [COMP_WIDTH-1:0] comp_ff;
   logic                    sat_ff;

   // split matrix entries and components into multiplier-sized parts
   for (genvar j = 0; j < 4; j++) begin : g_split
      assign lp_w[j][0] = $signed({1'b0, l_row[j][HALF_W-1:0]});
      assign lp_w[j][1] = 25'($signed(l_row[j][MAT_W-1:HALF_W]));
      for (genvar c = 0; c < NV; c++) begin : g_chunk
         if (c < NV - 1) begin : g_lo
            assign vc_w[j][c] = $signed({1'b0, v[j][32*c +: 32]});
         end else begin : g_top
            assign vc_w[j][c] = 33'($signed(v[j][COMP_WIDTH-1:32*c]));
         end
      end
   end

   // partial products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            for (int a = 0; a < 2; a++) begin
               for (int c = 0; c < NV; c++) begin
                  pp_ff[j][a][c] <= lp_w[j][a] * vc_w[j][c];
               end
            end
         end
      end
   end

   // recombine each column product
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         col_w[j] = '0;
         for (int a = 0; a < 2; a++) begin
            for (int c = 0; c < NV; c++) begin
               col_w[j] = col_w[j] + (ACC_W'(pp_ff[j][a][c]) <<< (HALF_W * a + 32 * c));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff <= col_w;
         acc_ff <= col_ff[0] + col_ff[1] + col_ff[2] + col_ff[3] + RND;
      end
   end

   // drop the fraction and clip to the component range
   assign sh_w = acc_ff[ACC_W-1:30];
   assign fits = (&sh_w[SH_W-1:COMP_WIDTH-1]) || !(|sh_w[SH_W-1:COMP_WIDTH-1]);

   always_ff @(posedge clock) begin
      if (en) begin
         comp_ff <= fits ? sh_w[COMP_WIDTH-1:0] : (sh_w[SH_W-1] ? MINV : MAXV);
         sat_ff  <= !fits;
      end
   end

   assign comp_out = comp_ff;
   assign sat_out  = sat_ff;

endmodule

`default_nettype wire

FILE: src/lorentz_boost_four_vector_top.sv
// data moves through the input register, the second stage, the shared front
// chain, the matrix stages, the lane stages and one output register; the depth is
// set by the 32-step divider and the cordic rotations sharing one stage chain
// throughput: one transfer per cycle unless the skid holds a stalled result
// reset: synchronous, active high, clears stage valids and output and skid valids
`default_nettype none

`include "assert_macros.svh"

module lorentz_boost_four_vector_top
   import blf_pkg::*;
#(
   parameter int COMP_WIDTH   = COMP_WIDTH_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // beta, gamma, mu, phi, energy_in, px_in, py_in, pz_in, zero pad
   input  logic [((127 + 4 * COMP_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // energy_out, px_out, py_out, pz_out, zero pad
   output logic [((4 * COMP_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // saturated
   output logic rsp_tuser
);

   localparam int RSP_W = ((4 * COMP_WIDTH + 7) / 8) * 8;
   localparam int NF    = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;
   localparam int VD    = NF + 7;
   localparam int LAT   = NF + 11;
   localparam int V_LSB = 127;
   localparam logic [COMP_WIDTH-1:0] MAXV = {1'b0, {(COMP_WIDTH-1){1'b1}}};
   localparam logic [COMP_WIDTH-1:0] MINV = {1'b1, {(COMP_WIDTH-1){1'b0}}};

   logic en;
   logic [LAT-1:0] vld_ff;
   front_type s1_in, s1_ff, f0_in, f0_ff;
   front_type st_w [NF+1];
   logic signed [COMP_WIDTH-1:0] v_in [4];
   logic signed [COMP_WIDTH-1:0] v_pipe_ff [VD][4];
   mval_type l_mat [4][4];
   logic signed [COMP_WIDTH-1:0] lane_comp [4];
   logic [3:0] lane_sat;
   logic signed [ANG_W-1:0] a0, a1, a2;
   logic signed [63:0] mu_sq;
   logic [63:0] g_sq;
   logic arrive;
   logic [RSP_W-1:0] merged;
   logic out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic load_out, load_skid, from_skid;
   logic [RSP_W-1:0] out_data_ff, skid_data_ff;
   logic out_sat_ff, skid_sat_ff;
   logic sat_hit;

   // pipeline moves while the skid entry is free
   assign en         = !skid_vld_ff;
   assign req_tready = en;

   // input stage: clamp, phase reduction to the right half plane
   always_comb begin
      s1_in      = '0;
      s1_in.beta = clamp_q30(36'($signed(req_tdata[31:0])));
      s1_in.gam  = req_tdata[63:32];
      s1_in.mu   = clamp_q30(36'($signed(req_tdata[95:64])));
      a0 = $signed({2'b00, req_tdata[126:96], 2'b00});
      a1 = (a0 >= TWO_PI_Q30) ? a0 - TWO_PI_Q30 : a0;
      a2 = (a1 > PI_Q30) ? a1 - TWO_PI_Q30 : a1;
      s1_in.ang = a2;
      if (a2 > HALF_PI_Q30) begin
         s1_in.ang  = a2 - PI_Q30;
         s1_in.flip = 1'b1;
      end else if (a2 < -HALF_PI_Q30) begin
         s1_in.ang  = a2 + PI_Q30;
         s1_in.flip = 1'b1;
      end
      for (int j = 0; j < 4; j++) begin
         v_in[j] = $signed(req_tdata[V_LSB + j * COMP_WIDTH +: COMP_WIDTH]);
      end
   end

   // second stage: squares that seed the square root and the divider
   assign mu_sq = s1_ff.mu * s1_ff.mu;
   assign g_sq  = s1_ff.gam * s1_ff.gam;

   always_comb begin
      f0_in        = s1_ff;
      f0_in.cx     = CORDIC_GAIN;
      f0_in.cy     = '0;
      f0_in.sq_rem = 62'((64'd1 << 60) - 64'(mu_sq));
      f0_in.sq_res = '0;
      f0_in.dv_rem = {2'b00, g_sq[63:32]};
      f0_in.dv_lo  = g_sq[31:0];
      f0_in.dv_den = {1'b0, s1_ff.gam} + 33'd65536;
      f0_in.dv_quo = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         f0_ff <= f0_in;
         v_pipe_ff[0] <= v_in;
         for (int k = 1; k < VD; k++) begin
            v_pipe_ff[k] <= v_pipe_ff[k-1];
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // shared cordic, square root and divider chain
   assign st_w[0] = f0_ff;
   for (genvar k = 0; k < NF; k++) begin : g_front
      blf_front_stage #(
         .STEP         (k),
         .CORDIC_STEPS (CORDIC_STEPS)
      ) u_stage (
         .clock  (clock),
         .en     (en),
         .st_in  (st_w[k]),
         .st_out (st_w[k+1])
      );
   end

   blf_matrix u_matrix (
      .clock (clock),
      .en    (en),
      .fin   (st_w[NF]),
      .l_mat (l_mat)
   );

   // one lane per output component
   for (genvar i = 0; i < 4; i++) begin : g_lane
      blf_lane #(
         .COMP_WIDTH (COMP_WIDTH)
      ) u_lane (
         .clock    (clock),
         .en       (en),
         .l_row    (l_mat[i]),
         .v        (v_pipe_ff[VD-1]),
         .comp_out (lane_comp[i]),
         .sat_out  (lane_sat[i])
      );
   end

   // merge the lanes into one result
   assign merged = RSP_W'({lane_comp[3], lane_comp[2], lane_comp[1], lane_comp[0]});
   assign arrive = vld_ff[LAT-1] && en;

   // output register with one skid entry
   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      load_out    = 1'b0;
      load_skid   = 1'b0;
      from_skid   = 1'b0;
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            from_skid   = 1'b1;
            skid_vld_in = 1'b0;
         end
      end else if (arrive) begin
         if (!out_vld_ff || rsp_tready) begin
            load_out   = 1'b1;
            out_vld_in = 1'b1;
         end else begin
            load_skid   = 1'b1;
            skid_vld_in = 1'b1;
         end
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= merged;
         out_sat_ff  <= |lane_sat;
      end else if (from_skid) begin
         out_data_ff <= skid_data_ff;
         out_sat_ff  <= skid_sat_ff;
      end
      if (load_skid) begin
         skid_data_ff <= merged;
         skid_sat_ff  <= |lane_sat;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sat_ff;

   // some component sits at a range limit
   always_comb begin
      sat_hit = 1'b0;
      for (int j = 0; j < 4; j++) begin
         if (out_data_ff[j * COMP_WIDTH +: COMP_WIDTH] == MAXV
             || out_data_ff[j * COMP_WIDTH +: COMP_WIDTH] == MINV) begin
            sat_hit = 1'b1;
         end
      end
   end

   // checks
   `ASSERT_NEVER(a_skid_without_out, clock, reset, skid_vld_ff && !out_vld_ff, "skid full, output empty")
   `ASSERT_CLK(a_skid_on_stall, clock, reset, $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_tready), "skid loaded without stall")
   `ASSERT_CLK(a_sat_clipped, clock, reset, rsp_tvalid && rsp_tuser |-> sat_hit, "saturated flag without clipped component")

endmodule

`default_nettype wire

FILE: dv/tb_lorentz_boost_four_vector_top.sv
// self-checking testbench for lorentz_boost_four_vector_top: directed table, then random vectors
// depends on blf_pkg and the boost pipeline rtl; holds its own fixed-point boost predictor
`timescale 1ns / 100ps

module tb_lorentz_boost_four_vector_top;
   import blf_pkg::*;

   localparam int CW     = 48;
   localparam int REQ_W  = ((127 + 4 * CW + 7) / 8) * 8;
   localparam int RSP_W  = ((4 * CW + 7) / 8) * 8;
   localparam int N_RAND = 1450;

   localparam logic [CW-1:0] COMP_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COMP_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [31:0]   GAMMA_ONE = 32'd65536;

   typedef struct packed {
      logic [31:0]   beta;
      logic [31:0]   gamma;
      logic [31:0]   mu;
      logic [30:0]   phi;
      logic [CW-1:0] energy;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [CW-1:0] pz;
   } boost_req_type;

   typedef struct packed {
      logic [CW-1:0] energy;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [CW-1:0] pz;
      logic          sat;
   } boost_rsp_type;

   typedef struct {
      boost_req_type req;
      logic          known;
      boost_rsp_type rsp;
   } table_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;

   boost_rsp_type boosted_q[$];
   int            n_errors;
   logic          no_idle;
   logic          hold_request;

   lorentz_boost_four_vector_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic longint clip_unit(input longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned r);
      longint unsigned res;
      longint unsigned bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > r) bt = bt >> 2;
      while (bt != 0) begin
         if (r >= res + bt) begin
            r = r - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic longint arctan_step(input int i);
      longint arctan_rom[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                 33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return arctan_rom[i];
      if (i <= 30) return 64'sd1 <<< (30 - i);
      return 0;
   endfunction

   function automatic boost_rsp_type boost_vector(input boost_req_type r);
      longint beta, mu, ang, cx, cy, dx, dy, sin_t, cc;
      longint unsigned g;
      longint dir[3];
      longint bv[3];
      longint mat[4][4];
      logic signed [127:0] comp[4];
      logic signed [127:0] acc;
      logic signed [127:0] shifted;
      logic [CW-1:0] res[4];
      logic flip, sat;
      boost_rsp_type o;
      beta = clip_unit(longint'(signed'(r.beta)));
      mu   = clip_unit(longint'(signed'(r.mu)));
      g    = {32'd0, r.gamma};
      ang  = longint'({33'd0, r.phi}) <<< 2;
      cx   = 652032874;
      cy   = 0;
      flip = 1'b0;
      sat  = 1'b0;
      sin_t = longint'(int_sqrt((64'd1 << 60) - longint'(mu * mu)));
      // fold the azimuth into +-pi/2
      if (ang >= 64'sd6746518852) ang = ang - 64'sd6746518852;
      if (ang > 64'sd3373259426) ang = ang - 64'sd6746518852;
      if (ang > 64'sd1686629713) begin
         ang = ang - 64'sd3373259426;
         flip = 1'b1;
      end else if (ang < -64'sd1686629713) begin
         ang = ang + 64'sd3373259426;
         flip = 1'b1;
      end
      // rotation-mode cordic
      for (int i = 0; i < 30; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (ang >= 0) begin
            cx = cx - dx;
            cy = cy + dy;
            ang = ang - arctan_step(i);
         end else begin
            cx = cx + dx;
            cy = cy - dy;
            ang = ang + arctan_step(i);
         end
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      dir[0] = clip_unit((sin_t * cx) >>> 30);
      dir[1] = clip_unit((sin_t * cy) >>> 30);
      dir[2] = mu;
      for (int i = 0; i < 3; i++) bv[i] = (beta * dir[i]) >>> 30;
      cc = longint'((g * g) / (g + 64'd65536));
      // symmetric boost matrix in q30
      mat[0][0] = longint'(g) <<< 14;
      for (int i = 0; i < 3; i++) begin
         mat[0][i+1] = -((longint'(g) * bv[i]) >>> 16);
         mat[i+1][0] = mat[0][i+1];
         for (int j = 0; j < 3; j++)
            mat[i+1][j+1] = (i == j ? 64'sd1073741824 : 64'sd0)
                          + ((cc * ((bv[i] * bv[j]) >>> 30)) >>> 16);
      end
      comp[0] = 128'(signed'(r.energy));
      comp[1] = 128'(signed'(r.px));
      comp[2] = 128'(signed'(r.py));
      comp[3] = 128'(signed'(r.pz));
      // exact sums, round half up, saturate
      for (int i = 0; i < 4; i++) begin
         acc = 128'sd1 <<< 29;
         for (int j = 0; j < 4; j++) acc = acc + 128'(signed'(mat[i][j])) * comp[j];
         shifted = acc >>> 30;
         if (shifted > 128'(signed'(COMP_MAX))) begin
            res[i] = COMP_MAX;
            sat = 1'b1;
         end else if (shifted < 128'(signed'(COMP_MIN))) begin
            res[i] = COMP_MIN;
            sat = 1'b1;
         end else begin
            res[i] = shifted[CW-1:0];
         end
      end
      o.energy = res[0];
      o.px = res[1];
      o.py = res[2];
      o.pz = res[3];
      o.sat = sat;
      return o;
   endfunction

   // ---------------- stimulus ----------------

   function automatic logic [CW-1:0] rand_comp();
      logic [CW-1:0] v;
      v = CW'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: v = CW'(signed'(v[27:0]));        // small, well inside range
         1: v = CW'(signed'(v[39:0]));
         default: ;
      endcase
      return v;
   endfunction

   function automatic boost_req_type rand_boost();
      boost_req_type r;
      logic signed [31:0] b;
      int sel;
      sel = $urandom_range(0, 9);
      b = $urandom_range(0, 32'h4000_0000);
      r.beta  = $urandom_range(0, 1) ? b : -b;
      r.gamma = $urandom_range(65536, 65536 * 8);
      r.mu    = $urandom_range(0, 1) ? $urandom_range(0, 32'h4000_0000)
                                     : -$urandom_range(0, 32'h4000_0000);
      r.phi   = 31'($urandom_range(0, 1686629712));
      // some items use the full field ranges, out-of-range codes included
      if (sel == 0) begin
         r.beta = $urandom;
         r.mu = $urandom;
         r.gamma = $urandom;
         r.phi = 31'($urandom);
      end else if (sel == 1) begin
         r.gamma = $urandom;
      end
      r.energy = rand_comp();
      r.px = rand_comp();
      r.py = rand_comp();
      r.pz = rand_comp();
      return r;
   endfunction

   task automatic offer_item(input boost_req_type r, input logic known,
                             input boost_rsp_type want);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, r.pz, r.py, r.px, r.energy, r.phi, r.mu, r.gamma, r.beta};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      boosted_q.push_back(known ? want : boost_vector(r));
   endtask

   function automatic table_row_type mk_row(input logic [31:0] beta, input logic [31:0] gamma,
                                            input logic [31:0] mu, input logic [30:0] phi,
                                            input logic [CW-1:0] e, input logic [CW-1:0] x,
                                            input logic [CW-1:0] y, input logic [CW-1:0] z,
                                            input logic known, input boost_rsp_type want);
      table_row_type t;
      t.req = '{beta, gamma, mu, phi, e, x, y, z};
      t.known = known;
      t.rsp = want;
      return t;
   endfunction

   initial begin
      table_row_type directed[$];
      boost_rsp_type none;
      logic [CW-1:0] one_c;
      none = '0;
      one_c = CW'(1) << 24;
      // no boost: identity
      directed.push_back(mk_row(0, GAMMA_ONE, ONE_Q30, 0, one_c, 2 * one_c, 3 * one_c,
                                4 * one_c, 1, '{one_c, 2 * one_c, 3 * one_c, 4 * one_c, 0}));
      // zero vector stays zero whatever the boost
      directed.push_back(mk_row(32'h2000_0000, 32'd131072, 32'h1000_0000, 31'd12345,
                                0, 0, 0, 0, 1, none));
      // huge gamma with no speed clips the energy only
      directed.push_back(mk_row(0, 32'hFFFF_FFFF, 0, 0, COMP_MAX, 5, 7, 9, 1,
                                '{COMP_MAX, 48'd5, 48'd7, 48'd9, 1'b1}));
      directed.push_back(mk_row(0, 32'hFFFF_FFFF, 0, 0, COMP_MIN, COMP_MAX, COMP_MIN, 0, 1,
                                '{COMP_MIN, COMP_MAX, COMP_MIN, 48'd0, 1'b1}));
      // speed extremes, beyond one, inverse boost
      directed.push_back(mk_row(ONE_Q30, 32'hFFFF_FFFF, ONE_Q30, 0, one_c, 0, 0, one_c,
                                0, none));
      directed.push_back(mk_row(NEG_ONE_Q30, 32'd1 << 20, NEG_ONE_Q30, 31'h7FFF_FFFF,
                                one_c, one_c, one_c, one_c, 0, none));
      directed.push_back(mk_row(32'h7FFF_FFFF, 32'd150000, 32'h8000_0000, 0,
                                COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, 0, none));
      directed.push_back(mk_row(32'h8000_0000, 32'd150000, 32'h7FFF_FFFF, 31'd1686629712,
                                one_c, -one_c, one_c, -one_c, 0, none));
      // gamma below one, and zero
      directed.push_back(mk_row(32'h2000_0000, 0, 0, 31'd421657428, one_c, one_c, 0, 0,
                                0, none));
      directed.push_back(mk_row(32'h3000_0000, 32'd30000, 32'h0800_0000, 31'd843314856,
                                one_c, 0, one_c, 0, 0, none));
      // azimuth quadrants, pi, wrap past two pi, max code
      directed.push_back(mk_row(32'h3800_0000, 32'd200000, 0, 31'd421657428,
                                one_c, one_c, one_c, 0, 0, none));
      directed.push_back(mk_row(32'h3800_0000, 32'd200000, 0, 31'd843314856,
                                one_c, one_c, one_c, 0, 0, none));
      directed.push_back(mk_row(32'h3800_0000, 32'd200000, 0, 31'd1264972284,
                                one_c, one_c, one_c, 0, 0, none));
      directed.push_back(mk_row(32'h3800_0000, 32'd200000, 0, 31'd1686629713,
                                one_c, one_c, one_c, 0, 0, none));
      directed.push_back(mk_row(32'h3800_0000, 32'd200000, 32'hE000_0000, 31'h7FFF_FFFF,
                                one_c, one_c, one_c, one_c, 0, none));
      directed.push_back(mk_row(32'h3FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h5555_5555,
                                48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1, COMP_MIN + 1,
                                0, none));

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      no_idle      = 1'b0;
      hold_request = 1'b0;
      n_errors     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) offer_item(directed[k].req, directed[k].known, directed[k].rsp);
      for (int n = 0; n < N_RAND; n++) begin
         // alternate stretches with and without idling
         if (n % 100 == 0) no_idle <= ($urandom_range(0, 2) == 0);
         if (n == 400) hold_request <= 1'b1;
         offer_item(rand_boost(), 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (boosted_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------- result side ----------------

   // receiver pacing, with one long hold-off to back up the pipeline
   initial begin
      int gap;
      logic held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         gap = no_idle ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      boost_rsp_type got;
      boost_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[CW-1:0], rsp_tdata[2*CW-1:CW], rsp_tdata[3*CW-1:2*CW],
                 rsp_tdata[4*CW-1:3*CW], rsp_tuser};
         if (boosted_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            n_errors++;
         end else begin
            want = boosted_q.pop_front();
            if (got.energy !== want.energy) begin
               $display("%0t: energy exp %h got %h", $time, want.energy, got.energy);
               n_errors++;
            end
            if (got.px !== want.px) begin
               $display("%0t: px exp %h got %h", $time, want.px, got.px);
               n_errors++;
            end
            if (got.py !== want.py) begin
               $display("%0t: py exp %h got %h", $time, want.py, got.py);
               n_errors++;
            end
            if (got.pz !== want.pz) begin
               $display("%0t: pz exp %h got %h", $time, want.pz, got.pz);
               n_errors++;
            end
            if (got.sat !== want.sat) begin
               $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
               n_errors++;
            end
         end
      end
   end

   // run limit
   initial begin
      #3000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/blf_pkg.sv
src/blf_front_stage.sv
src/blf_matrix.sv
src/blf_lane.sv
src/lorentz_boost_four_vector_top.sv
dv/tb_lorentz_boost_four_vector_top.sv
